// ===== sv/scvs_pkg.sv =====
// ----------------------------------------------------------------------------
// scvs_pkg
// Shared types and codes for the second-chance victim selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package scvs_pkg;

	// item kinds (input tuser bit 0)
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_POOL_EMPTY  = 2'd1;
	localparam logic [1:0] ST_NO_UNFIXED  = 2'd2;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PAGE_SIZE  = 2'd0;
	localparam logic [1:0] CFG_TRAIN_SIZE = 2'd1;
	localparam logic [1:0] CFG_BULK_FLUSH = 2'd2;

	localparam int SIZE_W     = 9;
	localparam int SIZE_RESET = 256;
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	// one buffer entry as held in the entry RAM
	typedef struct packed {
		logic [7:0] fix;
		logic       refer;
		logic       dirty;
		logic       valid;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// decision of the entry evaluator for the entry under the hand
	typedef struct packed {
		logic   unfixed;
		logic   found;
		logic   wr_back;
		entry_t wr_word;
		logic   flush;
		logic   del;
	} eval_t;

endpackage

`default_nettype wire

// ===== sv/scvs_ram.sv =====
// ----------------------------------------------------------------------------
// scvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module scvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/scvs_entry_eval.sv =====
// ----------------------------------------------------------------------------
// scvs_entry_eval
// Shared per-entry unit: second-chance decision and clock hand advance.
// ----------------------------------------------------------------------------
`default_nettype none

module scvs_entry_eval #(
	parameter int IW = 8,
	parameter int NW = 9
) (
	input  scvs_pkg::entry_t word,
	input  wire [IW-1:0]     v,
	input  wire [NW-1:0]     n,
	output scvs_pkg::eval_t  res,
	output logic [IW-1:0]    next_v
);

	logic [NW-1:0] inc;

	always_comb begin
		res.unfixed = (word.fix == 8'd0);
		res.found   = res.unfixed && !word.refer;
		// unfixed entries always get their reference bit cleared
		res.wr_back = res.unfixed;
		res.wr_word.fix   = word.fix;
		res.wr_word.refer = 1'b0;
		res.wr_word.dirty = res.found ? 1'b0 : word.dirty;
		res.wr_word.valid = res.found ? 1'b0 : word.valid;
		res.flush = word.valid & word.dirty;
		res.del   = word.valid;
	end

	assign inc    = NW'(v) + NW'(1);
	assign next_v = (inc == n) ? '0 : IW'(inc);

endmodule

`default_nettype wire

// ===== sv/second_chance_victim_select_core.sv =====
// ----------------------------------------------------------------------------
// second_chance_victim_select_core
// Clock (second-chance) victim selection over a page pool and a train pool.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer per item. tuser selects the kind (allocate or
// write entry) and the pool; tdata carries the entry index and marks.
// Output stream m_*: exactly one result transfer per input item.
// Config port: cfg_we/cfg_index/cfg_data, to be written only while the block is idle; the block does not enforce this.
//
// One item at a time; s_tready is high only while idle. A write-entry item
// is written on acceptance and its result follows from DONE. An allocate
// walks the entry RAM from the pool's clock hand, visiting each entry in a
// READ state (registered RAM read) and an EVAL state (evaluate and write
// back), for at most two sweeps of the pool.
// After reset the entry RAM is swept clear, one entry a cycle, over both
// pools' entries (512 at the default) with s_tready low.
// The result sits in an output register; a stalled receiver holds it there
// and the block may take the next item meanwhile, but will not finish it
// until the previous result has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module second_chance_victim_select_core #(
	parameter int POOL_DEPTH = 256
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// tdata: entry_index[7:0], fix_count[15:8], refer_mark[16], dirty_mark[17],
	//        key_valid[18], zero[23:19]
	input  wire [scvs_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: opcode[0], pool[1]
	input  wire [scvs_pkg::IN_USER_W-1:0]     s_tuser,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// tdata: status[1:0], victim_index[9:2], flush_needed[10],
	//        delete_needed[11], zero[15:12]
	output logic [scvs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	input  wire                               cfg_we,
	input  wire [1:0]                         cfg_index,
	input  wire [scvs_pkg::SIZE_W-1:0]        cfg_data
);

	localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int AW = IW + 1;
	localparam int NW = $clog2(POOL_DEPTH + 1);
	localparam int CW = NW + 1;

	typedef enum logic [2:0] {CLEAR, IDLE, READ, EVAL, DONE} state_t;

	state_t state_q;

	logic [scvs_pkg::SIZE_W-1:0] page_size_q, train_size_q;
	logic                        bulk_q;

	logic [AW-1:0] clr_q;
	logic [IW-1:0] hand_q [2];
	logic          pool_q;
	logic [IW-1:0] v_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic          seen_q;

	logic [1:0] res_status_q;
	logic [7:0] res_victim_q;
	logic       res_flush_q, res_del_q;

	logic                              m_tvalid_q;
	logic [scvs_pkg::OUT_DATA_W-1:0]   m_tdata_q;

	// input fields
	logic                        in_op, in_pool;
	logic [7:0]                  in_idx, in_fix;
	logic                        in_ref, in_dirty, in_valid;
	logic                        accept, idx_ok;
	logic [scvs_pkg::SIZE_W-1:0] sel_size;
	logic [NW-1:0]               n_in;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	scvs_pkg::entry_t          ram_wdata, ram_rdata;
	scvs_pkg::eval_t           ev;
	logic [IW-1:0]             next_v;

	assign in_op    = s_tuser[0];
	assign in_pool  = s_tuser[1];
	assign in_idx   = s_tdata[7:0];
	assign in_fix   = s_tdata[15:8];
	assign in_ref   = s_tdata[16];
	assign in_dirty = s_tdata[17];
	assign in_valid = s_tdata[18];

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign idx_ok   = (32'(in_idx) < 32'(POOL_DEPTH));

	assign sel_size = in_pool ? train_size_q : page_size_q;
	assign n_in     = (32'(sel_size) > 32'(POOL_DEPTH)) ? NW'(POOL_DEPTH) : NW'(sel_size);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q  <= scvs_pkg::SIZE_W'(scvs_pkg::SIZE_RESET);
			train_size_q <= scvs_pkg::SIZE_W'(scvs_pkg::SIZE_RESET);
			bulk_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scvs_pkg::CFG_PAGE_SIZE:  page_size_q  <= cfg_data;
				scvs_pkg::CFG_TRAIN_SIZE: train_size_q <= cfg_data;
				scvs_pkg::CFG_BULK_FLUSH: bulk_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// entry RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {pool_q, v_q};
		ram_wdata = ev.wr_word;
		if (state_q == CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (accept && (in_op == scvs_pkg::OP_WRITE) && idx_ok) begin
			ram_we          = 1'b1;
			ram_waddr       = {in_pool, IW'(in_idx)};
			ram_wdata.fix   = in_fix;
			ram_wdata.refer = in_ref;
			ram_wdata.dirty = in_dirty;
			ram_wdata.valid = in_valid;
		end else if (state_q == EVAL && ev.wr_back) begin
			ram_we = 1'b1;
		end
	end

	assign ram_raddr = {pool_q, v_q};

	scvs_ram #(
		.WIDTH(scvs_pkg::ENTRY_W),
		.DEPTH(2 ** AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	scvs_entry_eval #(
		.IW(IW),
		.NW(NW)
	) u_eval (
		.word  (ram_rdata),
		.v     (v_q),
		.n     (n_q),
		.res   (ev),
		.next_v(next_v)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CLEAR;
			clr_q        <= '0;
			hand_q[0]    <= '0;
			hand_q[1]    <= '0;
			pool_q       <= 1'b0;
			v_q          <= '0;
			n_q          <= '0;
			i_q          <= '0;
			seen_q       <= 1'b0;
			res_status_q <= scvs_pkg::ST_OK;
			res_victim_q <= '0;
			res_flush_q  <= 1'b0;
			res_del_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// in DONE the output register is reloaded instead
			if (m_tvalid_q && m_tready && (state_q != DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						pool_q       <= in_pool;
						res_victim_q <= '0;
						res_flush_q  <= 1'b0;
						res_del_q    <= 1'b0;
						state_q      <= DONE;
						if (in_op == scvs_pkg::OP_WRITE) begin
							res_status_q <= scvs_pkg::ST_OK;
						end else if (bulk_q) begin
							res_status_q <= scvs_pkg::ST_UNSUPPORTED;
						end else if (n_in == '0) begin
							res_status_q <= scvs_pkg::ST_POOL_EMPTY;
						end else begin
							n_q    <= n_in;
							// hand left beyond a lowered pool size restarts at 0
							v_q    <= (NW'(hand_q[in_pool]) >= n_in) ? '0 : hand_q[in_pool];
							i_q    <= '0;
							seen_q <= 1'b0;
							state_q <= READ;
						end
					end
				end
				READ: begin
					if (((i_q == CW'(n_q)) && !seen_q) || (i_q == {n_q, 1'b0})) begin
						res_status_q <= scvs_pkg::ST_NO_UNFIXED;
						state_q      <= DONE;
					end else begin
						state_q <= EVAL;
					end
				end
				EVAL: begin
					if (ev.unfixed) begin
						seen_q <= 1'b1;
					end
					if (ev.found) begin
						hand_q[pool_q] <= next_v;
						res_status_q   <= scvs_pkg::ST_OK;
						res_victim_q   <= 8'(v_q);
						res_flush_q    <= ev.flush;
						res_del_q      <= ev.del;
						state_q        <= DONE;
					end else begin
						v_q     <= next_v;
						i_q     <= i_q + CW'(1);
						state_q <= READ;
					end
				end
				DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, res_del_q, res_flush_q, res_victim_q, res_status_q};
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/scvs_checker.sv =====
// ----------------------------------------------------------------------------
// scvs_checker
// Port-level checks for the victim selection core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scvs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// one item at a time: busy right after an input transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// error results carry no victim
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != 2'd0) |-> (m_tdata[11:2] == 10'd0))
		else $error("error result with victim fields set");

	// flush only for a valid victim, which also needs a hash delete
	a_flush_implies_delete: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[11])
		else $error("flush without delete");

endmodule

bind second_chance_victim_select_core scvs_checker u_scvs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
